@@ hdl/mdu_pkg.sv @@
// Shared types and constants for the 3D Mahalanobis distance unit.
// No dependencies; imported by mdu_divsqrt and mahalanobis_distance_3d_unit.
`timescale 1ns / 1ps

package mdu_pkg;

  localparam int DW = 100;
  localparam int QW = 132;
  localparam int RW = DW + 1;
  localparam int SW = 36;
  localparam int NDIV = 64;
  localparam int NSQ = 32;
  localparam int CW = DW - 1 + 48;

  localparam logic [2:0] SETTLE = 3'd7;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  localparam logic [2:0] REG_XX = 3'd0;
  localparam logic [2:0] REG_XY = 3'd1;
  localparam logic [2:0] REG_XZ = 3'd2;
  localparam logic [2:0] REG_YY = 3'd3;
  localparam logic [2:0] REG_YZ = 3'd4;
  localparam logic [2:0] REG_ZZ = 3'd5;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_DET   = 3'd1,
    ST_XX    = 3'd2,
    ST_MINOR = 3'd3,
    ST_FORM  = 3'd4
  } status_t;

  typedef struct packed {
    logic    valid;
    logic    last;
    status_t status;
    logic    sat;
  } side_t;

endpackage

@@ hdl/mdu_mul64.sv @@
// Two-stage signed 64x64 multiplier built from four 32x32 partial products.
// Standalone; used by mahalanobis_distance_3d_unit.
`timescale 1ns / 1ps

module mdu_mul64 (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [63:0]   a,
  input  logic signed [63:0]   b,
  output logic signed [127:0]  p
);

  logic signed [31:0] ah;
  logic signed [31:0] bh;
  logic signed [32:0] al;
  logic signed [32:0] bl;
  logic [63:0]        ll;
  logic signed [64:0] hl;
  logic signed [64:0] lh;
  logic signed [63:0] hh;
  logic signed [65:0] mid;

  assign ah = a[63:32];
  assign bh = b[63:32];
  assign al = {1'b0, a[31:0]};
  assign bl = {1'b0, b[31:0]};
  assign mid = hl + lh;

  always_ff @(posedge clk) begin
    if (en) begin
      ll <= a[31:0] * b[31:0];
      hl <= ah * bl;
      lh <= al * bh;
      hh <= ah * bh;
      p  <= {hh, 64'b0} + {{30{mid[65]}}, mid, 32'b0} + {64'b0, ll};
    end
  end

endmodule

@@ hdl/mdu_divsqrt.sv @@
// Pipelined restoring divider (one quotient bit a stage) and integer square root
// (one root bit a stage). Depends on mdu_pkg.
`timescale 1ns / 1ps

module mdu_divsqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic signed [mdu_pkg::DW-1:0] det,
  input  logic signed [mdu_pkg::QW-1:0] q,
  input  mdu_pkg::side_t                side_in,
  output mdu_pkg::side_t                side_out,
  output logic [31:0]                   distance
);
  import mdu_pkg::*;

  logic [RW-1:0] drem [0:NDIV];
  logic [63:0]   dnum [0:NDIV];
  logic [63:0]   dquo [0:NDIV];
  side_t         dsd  [0:NDIV];
  logic [RW-1:0] drem_next [0:NDIV];
  logic [63:0]   dnum_next [0:NDIV];
  logic [63:0]   dquo_next [0:NDIV];
  side_t         dsd_next  [0:NDIV];

  logic [SW-1:0] srem [0:NSQ];
  logic [31:0]   sroot [0:NSQ];
  logic [63:0]   sval [0:NSQ];
  side_t         ssd  [0:NSQ];
  logic [SW-1:0] srem_next [0:NSQ];
  logic [31:0]   sroot_next [0:NSQ];
  logic [63:0]   sval_next [0:NSQ];
  side_t         ssd_next  [0:NSQ];

  logic [RW-1:0] dv;
  logic [CW-1:0] big_q;
  logic [CW-1:0] big_d;
  logic [RW-1:0] rsh;
  logic [SW-1:0] r2;
  logic [SW-1:0] trial;

  assign dv    = RW'(det[DW-2:0]);
  assign big_q = CW'(q[QW-2:0]);
  assign big_d = {det[DW-2:0], 48'b0};

  always_comb begin
    drem_next[0]     = RW'(q[QW-2:48]);
    dnum_next[0]     = {q[47:0], 16'b0};
    dquo_next[0]     = '0;
    dsd_next[0]      = side_in;
    dsd_next[0].sat  = (big_q >= big_d);
    for (int k = 0; k < NDIV; k++) begin
      rsh = {drem[k][RW-2:0], dnum[k][63]};
      if (rsh >= dv) begin
        drem_next[k+1] = rsh - dv;
        dquo_next[k+1] = {dquo[k][62:0], 1'b1};
      end else begin
        drem_next[k+1] = rsh;
        dquo_next[k+1] = {dquo[k][62:0], 1'b0};
      end
      dnum_next[k+1] = {dnum[k][62:0], 1'b0};
      dsd_next[k+1]  = dsd[k];
    end
    srem_next[0]  = '0;
    sroot_next[0] = '0;
    sval_next[0]  = dquo[NDIV];
    ssd_next[0]   = dsd[NDIV];
    for (int j = 0; j < NSQ; j++) begin
      r2    = {srem[j][SW-3:0], sval[j][63:62]};
      trial = {2'b0, sroot[j], 2'b01};
      if (r2 >= trial) begin
        srem_next[j+1]  = r2 - trial;
        sroot_next[j+1] = {sroot[j][30:0], 1'b1};
      end else begin
        srem_next[j+1]  = r2;
        sroot_next[j+1] = {sroot[j][30:0], 1'b0};
      end
      sval_next[j+1] = {sval[j][61:0], 2'b0};
      ssd_next[j+1]  = ssd[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NDIV; k++) dsd[k].valid <= 1'b0;
      for (int j = 0; j <= NSQ; j++) ssd[j].valid <= 1'b0;
    end else if (en) begin
      for (int k = 0; k <= NDIV; k++) begin
        drem[k] <= drem_next[k];
        dnum[k] <= dnum_next[k];
        dquo[k] <= dquo_next[k];
        dsd[k]  <= dsd_next[k];
      end
      for (int j = 0; j <= NSQ; j++) begin
        srem[j]  <= srem_next[j];
        sroot[j] <= sroot_next[j];
        sval[j]  <= sval_next[j];
        ssd[j]   <= ssd_next[j];
      end
    end
  end

  assign side_out = ssd[NSQ];
  assign distance = (ssd[NSQ].status != ST_OK) ? 32'd0 :
                    ssd[NSQ].sat ? 32'hFFFF_FFFF : sroot[NSQ];

endmodule

@@ hdl/mahalanobis_distance_3d_unit.sv @@
// Top level of the 3D Mahalanobis distance unit: register file, adjugate and
// determinant pipeline, quadratic form pipeline and output skid buffer.
// Depends on mdu_pkg, mdu_mul64 and mdu_divsqrt.
`timescale 1ns / 1ps

// Usage:
// Requests arrive on in_valid/in_ready carrying diff_x, diff_y, diff_z (signed
// Q16.16) and last_in. Each request yields one result on out_valid/out_ready:
// distance (unsigned Q16.16, saturating at all ones), status and last_out.
// The covariance sits in six APB registers at byte addresses 0x00..0x14; write
// them only while no request is in flight.
// A result is offered once its request has passed the quadratic form pipeline, the
// divider and the root pipeline; one request is taken every cycle while in_ready is high.
// After reset, and after any register write, in_ready stays low while the
// adjugate and determinant settle.
// The whole pipeline advances as one; a two-entry output buffer lets it take
// requests while a result waits. When the receiver stalls and both entries
// hold results, the pipeline and in_ready hold until the cycle after a result
// is taken.

module mahalanobis_distance_3d_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] diff_x,
  input  logic signed [31:0] diff_y,
  input  logic signed [31:0] diff_z,
  input  logic               last_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        distance,
  output logic [2:0]         status,
  output logic               last_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mdu_pkg::*;

  logic signed [31:0] cxx, cxy, cxz, cyy, cyz, czz;
  logic               wr;
  logic [2:0]         settle;

  logic signed [63:0] m_yyzz, m_yzyz, m_xxzz, m_xzxz, m_xxyy, m_xyxy;
  logic signed [63:0] m_xzyz, m_xyzz, m_xyyz, m_xzyy, m_xyxz, m_xxyz;
  logic signed [63:0] a11, a22, a33, a12, a13, a23;
  logic signed [63:0] dh1, dh2, dh3;
  logic signed [64:0] dl1, dl2, dl3;
  logic signed [DW-1:0] t1, t2, t3, det;
  status_t            cfg_stat;

  logic               adv;
  logic               acc;
  side_t              pipe [1:5];
  logic signed [63:0] xx, yy, zz, xy, xz, yz;
  logic signed [127:0] p11, p22, p33, p12, p13, p23;
  logic signed [QW-1:0] sa, sb, qsum, q;

  side_t              ds_side;
  logic [31:0]        ds_dist;

  logic [1:0]         fill;
  logic               wptr, rptr;
  logic [31:0]        fd [0:1];
  status_t            fs [0:1];
  logic               fl [0:1];
  logic               push, pop;

  // register file
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cxx <= ONE_Q16;
      cxy <= '0;
      cxz <= '0;
      cyy <= ONE_Q16;
      cyz <= '0;
      czz <= ONE_Q16;
      settle <= SETTLE;
    end else begin
      if (wr) begin
        case (paddr[4:2])
          REG_XX:  cxx <= pwdata;
          REG_XY:  cxy <= pwdata;
          REG_XZ:  cxz <= pwdata;
          REG_YY:  cyy <= pwdata;
          REG_YZ:  cyz <= pwdata;
          REG_ZZ:  czz <= pwdata;
          default: ;
        endcase
      end
      if (wr) begin
        settle <= SETTLE;
      end else if (settle != 3'd0) begin
        settle <= settle - 3'd1;
      end
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_XX:  prdata = cxx;
      REG_XY:  prdata = cxy;
      REG_XZ:  prdata = cxz;
      REG_YY:  prdata = cyy;
      REG_YZ:  prdata = cyz;
      REG_ZZ:  prdata = czz;
      default: prdata = '0;
    endcase
  end

  // adjugate and determinant
  always_ff @(posedge clk) begin
    m_yyzz <= cyy * czz;
    m_yzyz <= cyz * cyz;
    m_xxzz <= cxx * czz;
    m_xzxz <= cxz * cxz;
    m_xxyy <= cxx * cyy;
    m_xyxy <= cxy * cxy;
    m_xzyz <= cxz * cyz;
    m_xyzz <= cxy * czz;
    m_xyyz <= cxy * cyz;
    m_xzyy <= cxz * cyy;
    m_xyxz <= cxy * cxz;
    m_xxyz <= cxx * cyz;

    a11 <= m_yyzz - m_yzyz;
    a22 <= m_xxzz - m_xzxz;
    a33 <= m_xxyy - m_xyxy;
    a12 <= m_xzyz - m_xyzz;
    a13 <= m_xyyz - m_xzyy;
    a23 <= m_xyxz - m_xxyz;

    dh1 <= cxx * $signed(a11[63:32]);
    dh2 <= cxy * $signed(a12[63:32]);
    dh3 <= cxz * $signed(a13[63:32]);
    dl1 <= cxx * $signed({1'b0, a11[31:0]});
    dl2 <= cxy * $signed({1'b0, a12[31:0]});
    dl3 <= cxz * $signed({1'b0, a13[31:0]});

    t1 <= (DW'(dh1) <<< 32) + DW'(dl1);
    t2 <= (DW'(dh2) <<< 32) + DW'(dl2);
    t3 <= (DW'(dh3) <<< 32) + DW'(dl3);

    det <= t1 + t2 + t3;

    if (det <= 0) begin
      cfg_stat <= ST_DET;
    end else if (cxx <= 0) begin
      cfg_stat <= ST_XX;
    end else if (a33 <= 0) begin
      cfg_stat <= ST_MINOR;
    end else begin
      cfg_stat <= ST_OK;
    end
  end

  // quadratic form pipeline
  assign adv      = (fill != 2'd2);
  assign in_ready = adv && (settle == 3'd0);
  assign acc      = in_valid && in_ready;
  assign qsum     = sa + (sb <<< 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 5; k++) pipe[k].valid <= 1'b0;
    end else if (adv) begin
      pipe[1].valid  <= acc;
      pipe[1].last   <= last_in;
      pipe[1].status <= ST_OK;
      pipe[1].sat    <= 1'b0;
      for (int k = 2; k <= 4; k++) pipe[k] <= pipe[k-1];
      pipe[5].valid <= pipe[4].valid;
      pipe[5].last  <= pipe[4].last;
      pipe[5].sat   <= pipe[4].sat;
      if (cfg_stat != ST_OK) begin
        pipe[5].status <= cfg_stat;
      end else if (qsum < 0) begin
        pipe[5].status <= ST_FORM;
      end else begin
        pipe[5].status <= ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xx <= diff_x * diff_x;
      yy <= diff_y * diff_y;
      zz <= diff_z * diff_z;
      xy <= diff_x * diff_y;
      xz <= diff_x * diff_z;
      yz <= diff_y * diff_z;
      sa <= p11 + p22 + p33;
      sb <= p12 + p13 + p23;
      q  <= qsum;
    end
  end

  mdu_mul64 u_m11 (.clk(clk), .en(adv), .a(a11), .b(xx), .p(p11));
  mdu_mul64 u_m22 (.clk(clk), .en(adv), .a(a22), .b(yy), .p(p22));
  mdu_mul64 u_m33 (.clk(clk), .en(adv), .a(a33), .b(zz), .p(p33));
  mdu_mul64 u_m12 (.clk(clk), .en(adv), .a(a12), .b(xy), .p(p12));
  mdu_mul64 u_m13 (.clk(clk), .en(adv), .a(a13), .b(xz), .p(p13));
  mdu_mul64 u_m23 (.clk(clk), .en(adv), .a(a23), .b(yz), .p(p23));

  mdu_divsqrt u_divsqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .det      (det),
    .q        (q),
    .side_in  (pipe[5]),
    .side_out (ds_side),
    .distance (ds_dist)
  );

  // output buffer
  assign push = adv && ds_side.valid;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
      wptr <= 1'b0;
      rptr <= 1'b0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fd[wptr] <= ds_dist;
      fs[wptr] <= ds_side.status;
      fl[wptr] <= ds_side.last;
    end
  end

  assign out_valid = (fill != 2'd0);
  assign distance  = fd[rptr];
  assign status    = fs[rptr];
  assign last_out  = fl[rptr];

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("output buffer overfilled");

  a_settle: assert property (@(posedge clk) disable iff (rst) wr |=> !in_ready)
    else $error("request taken while registers settle");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
      (out_valid && status != ST_OK) |-> distance == 32'd0)
    else $error("failed check with nonzero distance");

endmodule
